### rtl/mws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_pkg
// shared constants and types of the 3x3 window sum block
// ----------------------------------------------------------------------------
package mws_pkg;

    // window geometry
    localparam int WIN_N = 3;
    localparam int BLK_N = WIN_N * WIN_N;

    // frame result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // configuration registers
    localparam int ROWCNT_W   = 13;
    localparam int COLCNT_W   = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

    localparam logic [ROWCNT_W-1:0] ROW_COUNT_RESET = 13'd3;
    localparam logic [COLCNT_W-1:0] COL_COUNT_RESET = 11'd3;

    typedef struct packed {
        logic [QCNT_W-1:0] used;
        logic              empty;
    } q_stat_t;

endpackage

### rtl/mws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_in_if / mws_out_if
// valid/ready channels for matrix elements and block results
// ----------------------------------------------------------------------------
interface mws_in_if #(
    parameter int ELEM_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [ELEM_WIDTH-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

interface mws_out_if #(
    parameter int ELEM_WIDTH = 16,
    parameter int SUM_WIDTH  = 20,
    parameter int ROW_WIDTH  = 12,
    parameter int COL_WIDTH  = 10
);
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic signed [ELEM_WIDTH-1:0] block_element;
    logic signed [SUM_WIDTH-1:0]  best_sum;
    logic        [ROW_WIDTH-1:0]  best_row;
    logic        [COL_WIDTH-1:0]  best_col;
    logic                         last;

    modport source (output valid, output found, output block_element, output best_sum,
                    output best_row, output best_col, output last, input ready);
    modport sink   (input valid, input found, input block_element, input best_sum,
                    input best_row, input best_col, input last, output ready);
endinterface

### rtl/max_3x3_window_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_3x3_window_sum
// greatest 3x3 block sum over a raster-order matrix stream
// ----------------------------------------------------------------------------
// Takes one element word per cycle in row-major order for a frame of row_count
// by col_count elements (zero reads as one, values above MAX_ROWS / MAX_COLS
// saturate). Two line store rams, each MAX_COLS deep, feed a 3x3 window whose
// column sums are kept as it slides, so each block sum is a three-term add and
// compare; the greatest sum wins, the earliest block in raster order on a tie.
// After the last element of a frame the front pushes one frame result into a
// four-entry queue and immediately starts the next frame. The back drains that
// result as nine words, the block row by row with sum and top-left position on
// each and last set on the ninth; a frame smaller than 3x3 gives a single word
// with found low, all fields zero and last high. Throughput is one element per
// cycle, set by the one read and one write per cycle of each line store ram;
// din stalls only while the queue plus the frame ends still in the pipeline
// fill all four entries. When the queue was empty, the first result word is
// valid once the frame's last element has passed stage 1, stage 2 and the
// queue write. The line stores need no clearing after reset.
// ----------------------------------------------------------------------------
module max_3x3_window_sum #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 4096,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mws_in_if.sink                            din,
    mws_out_if.source                         dout,
    input  logic                              wr_en,
    input  logic [mws_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [mws_pkg::CFG_DATA_W-1:0]    wr_data
);

    // queue entry: nine elements, sum, row, column, found flag
    localparam int ENT_W = 9 * ELEM_WIDTH + (ELEM_WIDTH + 4) + $clog2(MAX_ROWS)
                           + $clog2(MAX_COLS) + 1;

    // configuration
    logic [mws_pkg::ROWCNT_W-1:0] row_count_reg;
    logic [mws_pkg::COLCNT_W-1:0] col_count_reg;

    // front to queue to back
    logic                 push;
    logic [ENT_W-1:0]     push_data;
    logic                 pop;
    logic [ENT_W-1:0]     head_data;
    mws_pkg::q_stat_t     q_stat;

    // register writes take effect at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= mws_pkg::ROW_COUNT_RESET;
            col_count_reg <= mws_pkg::COL_COUNT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                mws_pkg::CFG_ROW_COUNT:
                begin
                    row_count_reg <= wr_data[mws_pkg::ROWCNT_W-1:0];
                end
                mws_pkg::CFG_COL_COUNT:
                begin
                    col_count_reg <= wr_data[mws_pkg::COLCNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // intake, line stores, window, sums and best-block tracking
    mws_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .row_count (row_count_reg),
        .col_count (col_count_reg),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // finished frames waiting for the output side
    mws_fifo #(
        .WIDTH (ENT_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .stat      (q_stat)
    );

    // result words, one per cycle when dout is ready
    mws_back #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dout      (dout),
        .q_stat    (q_stat),
        .head_data (head_data),
        .pop       (pop)
    );

    // the front never pushes a frame result into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && (q_stat.used == mws_pkg::QCNT_W'(mws_pkg::QDEPTH))))
        else $error("frame result pushed into a full queue");

    // a pushed frame result is waiting in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_stat.empty)
        else $error("queue empty right after a push");

    // a frame with no full block is a single word
    assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && !dout.found) |-> dout.last)
        else $error("no-block result not marked last");

    // the words of one block follow without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.ready && !dout.last) |=> dout.valid)
        else $error("block words interrupted");

endmodule

### rtl/mws_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mws_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_fifo
// short queue of finished frame results between front and back
// ----------------------------------------------------------------------------
module mws_fifo #(
    parameter int WIDTH = 187
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    head_data,
    output mws_pkg::q_stat_t    stat
);

    logic [WIDTH-1:0]                  mem_reg [mws_pkg::QDEPTH];
    logic [mws_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [mws_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [mws_pkg::QCNT_W-1:0]        used_reg;
    logic [mws_pkg::QCNT_W-1:0]        used_next;

    always_comb
    begin
        used_next = used_reg;
        if (push && !pop)
        begin
            used_next = used_reg + mws_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            used_next = used_reg - mws_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + mws_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + mws_pkg::QPTR_W'(1);
            end
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data  = mem_reg[rd_ptr_reg];
    assign stat.used  = used_reg;
    assign stat.empty = (used_reg == '0);

endmodule

### rtl/mws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_front
// element intake, line stores, 3x3 window, block sum and best-block tracking
// ----------------------------------------------------------------------------
module mws_front #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 4096,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mws_in_if.sink                          din,
    input  logic [mws_pkg::ROWCNT_W-1:0]    row_count,
    input  logic [mws_pkg::COLCNT_W-1:0]    col_count,
    input  mws_pkg::q_stat_t                q_stat,
    output logic                            push,
    output logic [9*ELEM_WIDTH+2*ELEM_WIDTH+4+$clog2(MAX_ROWS)+$clog2(MAX_COLS)-ELEM_WIDTH:0]
                                            push_data
);

    localparam int EW    = ELEM_WIDTH;
    localparam int SW    = EW + 4;
    localparam int CSW   = EW + 2;
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RC_W  = RW + 1;
    localparam int CC_W  = CW + 1;
    localparam int QC_W  = mws_pkg::QCNT_W + 1;
    localparam int SUM_O = mws_pkg::BLK_N * EW;
    localparam int ROW_O = SUM_O + SW;
    localparam int COL_O = ROW_O + RW;
    localparam int FND_O = COL_O + CW;

    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    // clamped frame size
    logic [RC_W-1:0] rows_lim;
    logic [CC_W-1:0] cols_lim;

    // intake counters
    logic [RW-1:0] row_pos_reg;
    logic [CW-1:0] col_pos_reg;
    logic          accept;
    logic          calc;
    logic          row_end;
    logic          frame_end;

    // stage 1: line store data available
    logic                 s1_valid_reg;
    logic                 s1_calc_reg;
    logic                 s1_end_reg;
    logic [RW-1:0]        s1_row_reg;
    logic [CW-1:0]        s1_col_reg;
    logic signed [EW-1:0] s1_elem_reg;
    logic                 fwd_reg;
    logic signed [EW-1:0] fwd_a_reg;
    logic signed [EW-1:0] fwd_b_reg;
    logic [EW-1:0]        ram_a_q;
    logic [EW-1:0]        ram_b_q;
    logic signed [EW-1:0] a_cur;
    logic signed [EW-1:0] b_cur;

    // window and column sums
    logic signed [EW-1:0]  win_reg [mws_pkg::WIN_N][mws_pkg::WIN_N];
    logic signed [CSW-1:0] cs_reg  [mws_pkg::WIN_N];

    // stage 2: block sum and compare
    logic                 s2_valid_reg;
    logic                 s2_calc_reg;
    logic                 s2_end_reg;
    logic [RW-1:0]        s2_row_reg;
    logic [CW-1:0]        s2_col_reg;
    logic signed [SW-1:0] sum_s2;
    logic                 take;

    // best block so far
    logic signed [SW-1:0] max_sum_reg;
    logic [RW-1:0]        max_row_reg;
    logic [CW-1:0]        max_col_reg;
    logic signed [EW-1:0] best_reg [mws_pkg::BLK_N];
    logic                 any_found_reg;

    // frame result as pushed
    logic                 e_found;
    logic signed [SW-1:0] e_sum;
    logic [RW-1:0]        e_row;
    logic [CW-1:0]        e_col;
    logic signed [EW-1:0] e_blk [mws_pkg::BLK_N];

    always_comb
    begin
        if (row_count == '0)
        begin
            rows_lim = RC_W'(1);
        end
        else if (32'(row_count) > MAX_ROWS)
        begin
            rows_lim = RC_W'(MAX_ROWS);
        end
        else
        begin
            rows_lim = RC_W'(row_count);
        end
        if (col_count == '0)
        begin
            cols_lim = CC_W'(1);
        end
        else if (32'(col_count) > MAX_COLS)
        begin
            cols_lim = CC_W'(MAX_COLS);
        end
        else
        begin
            cols_lim = CC_W'(col_count);
        end
    end

    // room in the queue for every frame end already in flight plus this one
    assign din.ready = ({1'b0, q_stat.used} + QC_W'(s1_end_reg) + QC_W'(s2_end_reg))
                       < QC_W'(mws_pkg::QDEPTH);
    assign accept    = din.valid && din.ready;

    assign calc      = (row_pos_reg >= RW'(2)) && (col_pos_reg >= CW'(2));
    assign row_end   = ({1'b0, col_pos_reg} + CC_W'(1)) >= cols_lim;
    assign frame_end = row_end && (({1'b0, row_pos_reg} + RC_W'(1)) >= rows_lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_end_reg   <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_end_reg   <= accept && frame_end;
            if (accept)
            begin
                fwd_reg <= s1_valid_reg && (s1_col_reg == col_pos_reg);
                if (row_end)
                begin
                    col_pos_reg <= '0;
                    if (frame_end)
                    begin
                        row_pos_reg <= '0;
                    end
                    else
                    begin
                        row_pos_reg <= row_pos_reg + RW'(1);
                    end
                end
                else
                begin
                    col_pos_reg <= col_pos_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_calc_reg <= calc;
            s1_row_reg  <= row_pos_reg - RW'(2);
            s1_col_reg  <= col_pos_reg;
            s1_elem_reg <= din.element;
            fwd_a_reg   <= s1_elem_reg;
            fwd_b_reg   <= a_cur;
        end
    end

    // line stores: a holds the row above, b the row above that
    mws_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_COLS)
    ) u_line_a (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_elem_reg),
        .re    (accept),
        .raddr (col_pos_reg),
        .rdata (ram_a_q)
    );

    mws_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_COLS)
    ) u_line_b (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (a_cur),
        .re    (accept),
        .raddr (col_pos_reg),
        .rdata (ram_b_q)
    );

    // bypass when the previous word wrote the same column in the read cycle
    assign a_cur = fwd_reg ? fwd_a_reg : $signed(ram_a_q);
    assign b_cur = fwd_reg ? fwd_b_reg : $signed(ram_b_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < mws_pkg::WIN_N; r++)
            begin
                cs_reg[r] <= '0;
                for (int q = 0; q < mws_pkg::WIN_N; q++)
                begin
                    win_reg[r][q] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            for (int r = 0; r < mws_pkg::WIN_N; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= b_cur;
            win_reg[1][2] <= a_cur;
            win_reg[2][2] <= s1_elem_reg;
            cs_reg[0]     <= cs_reg[1];
            cs_reg[1]     <= cs_reg[2];
            cs_reg[2]     <= CSW'(b_cur) + CSW'(a_cur) + CSW'(s1_elem_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_end_reg   <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_end_reg   <= s1_end_reg;
        end
    end

    // left column of the block that ends at this element
    always_ff @(posedge clk)
    begin
        s2_calc_reg <= s1_calc_reg;
        s2_row_reg  <= s1_row_reg;
        s2_col_reg  <= s1_col_reg - CW'(2);
    end

    assign sum_s2 = SW'(cs_reg[0]) + SW'(cs_reg[1]) + SW'(cs_reg[2]);
    assign take   = s2_valid_reg && s2_calc_reg && (sum_s2 > max_sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sum_reg   <= SUM_MIN;
            max_row_reg   <= '0;
            max_col_reg   <= '0;
            any_found_reg <= 1'b0;
            for (int k = 0; k < mws_pkg::BLK_N; k++)
            begin
                best_reg[k] <= '0;
            end
        end
        else if (push)
        begin
            // frame done: back to the empty state for the next one
            max_sum_reg   <= SUM_MIN;
            max_row_reg   <= '0;
            max_col_reg   <= '0;
            any_found_reg <= 1'b0;
            for (int k = 0; k < mws_pkg::BLK_N; k++)
            begin
                best_reg[k] <= '0;
            end
        end
        else if (take)
        begin
            max_sum_reg   <= sum_s2;
            max_row_reg   <= s2_row_reg;
            max_col_reg   <= s2_col_reg;
            any_found_reg <= 1'b1;
            for (int r = 0; r < mws_pkg::WIN_N; r++)
            begin
                for (int q = 0; q < mws_pkg::WIN_N; q++)
                begin
                    best_reg[r*mws_pkg::WIN_N+q] <= win_reg[r][q];
                end
            end
        end
    end

    // result of the frame including the block of its last element
    always_comb
    begin
        e_found = take || any_found_reg;
        e_sum   = '0;
        e_row   = '0;
        e_col   = '0;
        for (int k = 0; k < mws_pkg::BLK_N; k++)
        begin
            e_blk[k] = '0;
        end
        if (take)
        begin
            e_sum = sum_s2;
            e_row = s2_row_reg;
            e_col = s2_col_reg;
            for (int r = 0; r < mws_pkg::WIN_N; r++)
            begin
                for (int q = 0; q < mws_pkg::WIN_N; q++)
                begin
                    e_blk[r*mws_pkg::WIN_N+q] = win_reg[r][q];
                end
            end
        end
        else if (any_found_reg)
        begin
            e_sum = max_sum_reg;
            e_row = max_row_reg;
            e_col = max_col_reg;
            for (int k = 0; k < mws_pkg::BLK_N; k++)
            begin
                e_blk[k] = best_reg[k];
            end
        end
    end

    assign push = s2_valid_reg && s2_end_reg;

    always_comb
    begin
        push_data = '0;
        for (int k = 0; k < mws_pkg::BLK_N; k++)
        begin
            push_data[k*EW +: EW] = e_blk[k];
        end
        push_data[SUM_O +: SW] = e_sum;
        push_data[ROW_O +: RW] = e_row;
        push_data[COL_O +: CW] = e_col;
        push_data[FND_O]       = e_found;
    end

endmodule

### rtl/mws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mws_back
// drains one frame result from the queue as nine words, or one if none found
// ----------------------------------------------------------------------------
module mws_back #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 4096,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mws_out_if.source            dout,
    input  mws_pkg::q_stat_t     q_stat,
    input  logic [9*ELEM_WIDTH+2*ELEM_WIDTH+4+$clog2(MAX_ROWS)+$clog2(MAX_COLS)-ELEM_WIDTH:0]
                                 head_data,
    output logic                 pop
);

    localparam int EW    = ELEM_WIDTH;
    localparam int SW    = EW + 4;
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int KW    = $clog2(mws_pkg::BLK_N);
    localparam int SUM_O = mws_pkg::BLK_N * EW;
    localparam int ROW_O = SUM_O + SW;
    localparam int COL_O = ROW_O + RW;
    localparam int FND_O = COL_O + CW;

    logic [KW-1:0]        k_reg;
    logic signed [EW-1:0] blk [mws_pkg::BLK_N];
    logic                 found_h;
    logic                 last_w;
    logic                 xfer;

    always_comb
    begin
        for (int k = 0; k < mws_pkg::BLK_N; k++)
        begin
            blk[k] = head_data[k*EW +: EW];
        end
    end

    assign found_h = head_data[FND_O];
    assign last_w  = !found_h || (k_reg == KW'(mws_pkg::BLK_N - 1));
    assign xfer    = dout.valid && dout.ready;
    assign pop     = xfer && last_w;

    assign dout.valid         = !q_stat.empty;
    assign dout.found         = found_h;
    assign dout.block_element = blk[k_reg];
    assign dout.best_sum      = head_data[SUM_O +: SW];
    assign dout.best_row      = head_data[ROW_O +: RW];
    assign dout.best_col      = head_data[COL_O +: CW];
    assign dout.last          = last_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (xfer)
        begin
            if (last_w)
            begin
                k_reg <= '0;
            end
            else
            begin
                k_reg <= k_reg + KW'(1);
            end
        end
    end

endmodule
